FILE: rtl/mswd_pkg.sv
`default_nettype none
package mswd_pkg;

  localparam int MAX_SLOTS_DEF = 16;

  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_CHECKIN  = 3'd1;
  localparam logic [2:0] OP_SUSPEND  = 3'd2;
  localparam logic [2:0] OP_RESUME   = 3'd3;
  localparam logic [2:0] OP_MONITOR  = 3'd4;

  localparam logic [1:0] MODE_FREE      = 2'd0;
  localparam logic [1:0] MODE_ACTIVE    = 2'd1;
  localparam logic [1:0] MODE_SUSPENDED = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [2:0] RES_OK      = 3'd0;
  localparam logic [2:0] RES_FULL    = 3'd1;
  localparam logic [2:0] RES_INVALID = 3'd2;
  localparam logic [2:0] RES_NEW     = 3'd3;
  localparam logic [2:0] RES_FEED    = 3'd4;
  localparam logic [2:0] RES_FOUND   = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  slot_index;
    logic [30:0] limit_ms;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] new_slot;
    logic       feed;
    logic       timeout_found;
    logic [5:0] first_timeout_slot;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [30:0] timeout;
    logic [31:0] stamp;
  } slot_t;

  typedef struct packed {
    logic       cap_in;
    logic       alloc_wr;
    logic       rmw_wr;
    logic       rd_slot;
    logic       rd_first;
    logic       scan_step;
    logic       res_ld;
    logic [2:0] res_sel;
    logic       out_ld;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       idx_ok;
    logic       pool_full;
    logic       cnt_zero;
    logic       late;
    logic       scan_last;
    logic       out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/mswd_ram.sv
`default_nettype none
module mswd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/mswd_ctrl.sv
`default_nettype none
module mswd_ctrl
  import mswd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_sel = RES_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_REGISTER: begin
            cmd.res_ld = 1'b1;
            state_nxt  = S_DONE;
            if (sts.pool_full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.alloc_wr = 1'b1;
              cmd.res_sel  = RES_NEW;
            end
          end
          OP_CHECKIN, OP_SUSPEND, OP_RESUME: begin
            if (!sts.idx_ok) begin
              cmd.res_ld  = 1'b1;
              cmd.res_sel = RES_INVALID;
              state_nxt   = S_DONE;
            end else begin
              cmd.rd_slot = 1'b1;
              state_nxt   = S_RMW;
            end
          end
          OP_MONITOR: begin
            if (sts.cnt_zero) begin
              cmd.res_ld  = 1'b1;
              cmd.res_sel = RES_FEED;
              state_nxt   = S_DONE;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          default: begin
            cmd.res_ld = 1'b1;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_RMW: begin
        cmd.rmw_wr = 1'b1;
        cmd.res_ld = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        if (sts.late) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_FOUND;
          state_nxt   = S_DONE;
        end else if (sts.scan_last) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_FEED;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.alloc_wr, cmd.rmw_wr, cmd.scan_step}))
    else $error("more than one datapath update at once");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> state_r == S_IDLE)
    else $error("no return to idle after result load");

  a_cap_disp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_in |=> state_r == S_DISP)
    else $error("accepted word not dispatched");

endmodule
`default_nettype wire

FILE: rtl/mswd_dp.sv
`default_nettype none
module mswd_dp
  import mswd_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data,
  input  wire ctl_cmd_t  cmd,
  output dp_sts_t        sts
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int SW = $bits(slot_t);

  in_word_t       item_r;
  out_word_t      res_r, res_nxt;
  out_word_t      out_r;
  logic           out_valid_r;
  logic [CW-1:0]  count_r;
  logic [AW-1:0]  scan_r;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic           we;
  slot_t          wslot;
  slot_t          rslot;
  logic [31:0]    age;
  logic [CW-1:0]  scan_inc;

  assign scan_inc = CW'(scan_r) + CW'(1);
  assign age      = item_r.now_ms - rslot.stamp;

  assign sts.op        = item_r.operation;
  assign sts.idx_ok    = {1'b0, item_r.slot_index} < 7'(count_r);
  assign sts.pool_full = (count_r == CW'(MAX_SLOTS));
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.late      = (rslot.mode == MODE_ACTIVE) && !age[31] &&
                         (age[30:0] > rslot.timeout);
  assign sts.scan_last = (scan_inc == count_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (cmd.rd_slot) begin
      raddr = item_r.slot_index[AW-1:0];
    end else if (cmd.rd_first) begin
      raddr = '0;
    end else begin
      raddr = scan_inc[AW-1:0];
    end
  end

  always_comb begin
    we    = cmd.alloc_wr || cmd.rmw_wr;
    wslot = rslot;
    waddr = item_r.slot_index[AW-1:0];
    if (cmd.alloc_wr) begin
      waddr         = count_r[AW-1:0];
      wslot.mode    = MODE_ACTIVE;
      wslot.timeout = item_r.limit_ms;
      wslot.stamp   = item_r.now_ms;
    end else begin
      case (item_r.operation)
        OP_CHECKIN: begin
          if (rslot.mode == MODE_ACTIVE) begin
            wslot.stamp = item_r.now_ms;
          end
        end
        OP_SUSPEND: begin
          wslot.mode = MODE_SUSPENDED;
        end
        OP_RESUME: begin
          wslot.mode  = MODE_ACTIVE;
          wslot.stamp = item_r.now_ms;
        end
        default: begin
          wslot = rslot;
        end
      endcase
    end
  end

  mswd_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wslot),
    .raddr(raddr),
    .rdata(rslot)
  );

  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      RES_FULL: begin
        res_nxt.status = ST_FULL;
      end
      RES_INVALID: begin
        res_nxt.status = ST_INVALID;
      end
      RES_NEW: begin
        res_nxt.new_slot = 6'(count_r);
      end
      RES_FEED: begin
        res_nxt.feed = 1'b1;
      end
      RES_FOUND: begin
        res_nxt.timeout_found      = 1'b1;
        res_nxt.first_timeout_slot = 6'(scan_r);
      end
      default: begin
        res_nxt.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
    end else begin
      if (cmd.alloc_wr) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.rd_first) begin
        scan_r <= '0;
      end else if (cmd.scan_step) begin
        scan_r <= scan_inc[AW-1:0];
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      item_r <= in_data;
    end
    if (cmd.res_ld) begin
      res_r <= res_nxt;
    end
    if (cmd.out_ld) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SLOTS))
    else $error("slot count above pool size");

  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> !sts.pool_full)
    else $error("allocation into a full pool");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !(out_valid_r && out_stall))
    else $error("result word overwritten while stalled");

endmodule
`default_nettype wire

FILE: rtl/multi_slot_watchdog_monitor.sv
`default_nettype none
// Watchdog supervisor for up to MAX_SLOTS clients, kept in one slot RAM
// (mode, timeout, stamp per slot). Each input word carries one operation and
// the current ms tick; each yields exactly one result word. One word is in
// work at a time. Register, unknown ops and any invalid or full case pass
// from accept through dispatch to the done state, which loads the result and
// returns to idle; checkin, suspend and resume add one read-modify-write of
// the slot RAM; monitor on a non-empty pool adds a scan that reads slots in
// order up to the first timed-out one or the end of the allocated range (at
// most MAX_SLOTS), one slot per cycle through the RAM read port and one
// subtract-compare. A stalled result word holds the next result in the done
// state until it is taken. Slots are allocated in order and only allocated
// entries are ever read, so no clearing pass follows reset.
module multi_slot_watchdog_monitor
  import mswd_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  mswd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  mswd_dp #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mswd_pkg::*;

  localparam int NSLOTS = MAX_SLOTS_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  multi_slot_watchdog_monitor DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the slot table
  logic [30:0] slot_limit_ms[NSLOTS];
  logic [31:0] slot_seen_ms[NSLOTS];
  logic [1:0] slot_mode_r[NSLOTS];
  int slots_used = 0;

  out_word_t result_q[$];
  int errors = 0;
  bit gaps_off = 1'b0;
  logic [31:0] ms_now = 32'hFFFF_F000;

  function automatic out_word_t watchdog_result(in_word_t w);
    out_word_t r;
    logic idx_ok;
    logic [31:0] age;
    logic hit;
    r = '0;
    hit = 1'b0;
    idx_ok = w.slot_index < slots_used;
    case (w.operation)
      OP_REGISTER: begin
        if (slots_used >= NSLOTS) begin
          r.status = ST_FULL;
        end else begin
          slot_limit_ms[slots_used] = w.limit_ms;
          slot_seen_ms[slots_used] = w.now_ms;
          slot_mode_r[slots_used] = MODE_ACTIVE;
          r.new_slot = 6'(slots_used);
          slots_used++;
        end
      end
      OP_CHECKIN: begin
        if (!idx_ok) begin
          r.status = ST_INVALID;
        end else if (slot_mode_r[w.slot_index] == MODE_ACTIVE) begin
          slot_seen_ms[w.slot_index] = w.now_ms;
        end
      end
      OP_SUSPEND: begin
        if (!idx_ok) begin
          r.status = ST_INVALID;
        end else begin
          slot_mode_r[w.slot_index] = MODE_SUSPENDED;
        end
      end
      OP_RESUME: begin
        if (!idx_ok) begin
          r.status = ST_INVALID;
        end else begin
          slot_seen_ms[w.slot_index] = w.now_ms;
          slot_mode_r[w.slot_index] = MODE_ACTIVE;
        end
      end
      OP_MONITOR: begin
        r.feed = 1'b1;
        for (int i = 0; i < slots_used; i++) begin
          age = w.now_ms - slot_seen_ms[i];
          // negative age (bit 31 set) counts as healthy
          if (!hit && slot_mode_r[i] == MODE_ACTIVE && !age[31] &&
              age > {1'b0, slot_limit_ms[i]}) begin
            hit = 1'b1;
            r.feed = 1'b0;
            r.timeout_found = 1'b1;
            r.first_timeout_slot = 6'(i);
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_word_t make_word(logic [2:0] op, logic [5:0] idx,
                                         logic [30:0] tmo, logic [31:0] now);
    in_word_t w;
    w.operation = op;
    w.slot_index = idx;
    w.limit_ms = tmo;
    w.now_ms = now;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    result_q.push_back(watchdog_result(w));
    gap = gaps_off ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_field(string name, longint unsigned exp, longint unsigned got);
    if (exp != got) begin
      $display("%0t %s expected %0h got %0h", $time, name, exp, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected word expected none got %p", $time, out_data);
        errors++;
      end else begin
        exp = result_q.pop_front();
        report_field("status", exp.status, out_data.status);
        report_field("new_slot", exp.new_slot, out_data.new_slot);
        report_field("feed", exp.feed, out_data.feed);
        report_field("timeout_found", exp.timeout_found, out_data.timeout_found);
        report_field("first_timeout_slot", exp.first_timeout_slot,
                     out_data.first_timeout_slot);
      end
    end
  end

  // result side back-pressure, with quiet stretches
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic test_basic_ops();
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'd0));
    send_word(make_word(OP_REGISTER, 6'd0, 31'd0, 32'd0));
    send_word(make_word(OP_REGISTER, 6'd63, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'd1));
    send_word(make_word(OP_CHECKIN, 6'd0, 31'h7FFF_FFFF, 32'd1));
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'd1));
    send_word(make_word(OP_SUSPEND, 6'd0, 31'd0, 32'd5));
    send_word(make_word(OP_SUSPEND, 6'd0, 31'd0, 32'd6));
    send_word(make_word(OP_CHECKIN, 6'd0, 31'd0, 32'd9));
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'd9));
    send_word(make_word(OP_RESUME, 6'd0, 31'd0, 32'd20));
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'd20));
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'd21));
    send_word(make_word(OP_RESUME, 6'd0, 31'd0, 32'd21));
  endtask

  task automatic test_invalid_slots();
    send_word(make_word(OP_CHECKIN, 6'd2, 31'd0, 32'd30));
    send_word(make_word(OP_SUSPEND, 6'd63, 31'd0, 32'd30));
    send_word(make_word(OP_RESUME, 6'd17, 31'd0, 32'd30));
  endtask

  task automatic test_wrap_age();
    send_word(make_word(OP_SUSPEND, 6'd0, 31'd0, 32'd40));
    send_word(make_word(OP_REGISTER, 6'd0, 31'd100, 32'hFFFF_FFF0));
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'h0000_0050));
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'h0000_0055));
    send_word(make_word(OP_MONITOR, 6'd0, 31'd0, 32'h7FFF_FFF0));
  endtask

  task automatic test_unknown_ops();
    for (int k = 1; k <= 3; k++) begin
      send_word(make_word(3'(OP_MONITOR + k), 6'($urandom), 31'($urandom), $urandom()));
    end
  endtask

  task automatic test_pool_full();
    while (slots_used < NSLOTS) begin
      send_word(make_word(OP_REGISTER, 6'd0, 31'($urandom_range(0, 300)), ms_now));
    end
    send_word(make_word(OP_REGISTER, 6'd0, 31'd5, ms_now));
    send_word(make_word(OP_REGISTER, 6'h3F, 31'h7FFF_FFFF, $urandom()));
  endtask

  task automatic run_random(int n_items);
    in_word_t w;
    int r;
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) gaps_off = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) ms_now += $urandom();
      else ms_now += $urandom_range(0, 40);
      r = $urandom_range(0, 99);
      w = make_word(OP_MONITOR, 6'd0, 31'($urandom), ms_now);
      if (slots_used > 0 && $urandom_range(0, 9) < 8) w.slot_index = 6'($urandom_range(0, slots_used - 1));
      else w.slot_index = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 9) != 0) w.limit_ms = 31'($urandom_range(0, 300));
      if (r < 4) w.operation = OP_REGISTER;
      else if (r < 38) w.operation = OP_CHECKIN;
      else if (r < 48) w.operation = OP_SUSPEND;
      else if (r < 58) w.operation = OP_RESUME;
      else if (r < 92) w.operation = OP_MONITOR;
      else if (r < 96) w.operation = 3'(OP_MONITOR + $urandom_range(1, 3));
      else w = in_word_t'(72'({$urandom(), $urandom(), $urandom()}));
      send_word(w);
    end
    gaps_off = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_invalid_slots();
    test_wrap_age();
    test_unknown_ops();
    run_random(350);
    test_pool_full();
    run_random(520);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
